/* design/spkat_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// spkat_pkg
// Shared types and codes for the sorted pair-key accumulate table.
// ---------------------------------------------------------------------------
package spkat_pkg;

    // command codes
    localparam logic [1:0] CMD_ADD   = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_WRITE = 2'd2;
    localparam logic [1:0] CMD_CLEAR = 2'd3;

    // result status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_MERGED = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;
    localparam logic [1:0] ST_RANGE  = 2'd3;

    // level rule codes
    localparam logic [1:0] LA_ADD = 2'd0;
    localparam logic [1:0] LA_SUB = 2'd1;
    localparam logic [1:0] LA_OVR = 2'd2;

    typedef struct packed {
        logic [1:0]         cmd;
        logic [15:0]        item_key;
        logic [7:0]         supplier_key;
        logic [7:0]         position;
        logic signed [31:0] import_primary_qty;
        logic signed [31:0] import_stock_qty;
        logic signed [31:0] current_qty;
        logic               selected;
    } t_in;

    typedef struct packed {
        logic [1:0]         status;
        logic [8:0]         entry_position;
        logic [15:0]        entry_item_key;
        logic [7:0]         entry_supplier_key;
        logic signed [31:0] entry_current_qty;
        logic signed [31:0] entry_primary_qty;
        logic signed [31:0] entry_stock_qty;
        logic               entry_selected;
        logic signed [31:0] new_level;
        logic [8:0]         entry_total;
        logic [8:0]         selected_total;
        logic               selection_changed;
    } t_out;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ACCESS,
        S_ACC_DATA,
        S_SEARCH,
        S_PROBE,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_EMIT
    } t_state;

endpackage

/* design/spkat_mem.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// spkat_mem
// Entry memory: one write port, one read port with registered read data.
// ---------------------------------------------------------------------------
module spkat_mem #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 121
) (
    input  logic                     i_clk,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // read port, registered read data
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* design/sorted_pair_key_accumulate_table.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sorted_pair_key_accumulate_table
// Sorted key table with binary search, merge-or-insert and positional access.
// ---------------------------------------------------------------------------
// One item is worked at a time, all through one entry memory with a registered
// read. Clear goes straight to the result; read and write check the range, read
// the entry and, for a write, store it. An add reads one entry per search probe
// (at most log2(TABLE_DEPTH)+1 probes), and on an insert moves each entry above
// the slot up by one, top first, with a read and a write, then writes the new
// entry. The result sits in an output register, and the next item is taken
// once the block is back in idle even while that result is still stalled.
module sorted_pair_key_accumulate_table #(
    parameter int TABLE_DEPTH = 256,
    parameter int QTY_WIDTH   = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  spkat_pkg::t_in    i_in_item,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output spkat_pkg::t_out   o_out_item,
    input  logic              i_cfg_wr_en,
    input  logic [1:0]        i_cfg_wr_data
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int XW = (QTY_WIDTH > 32) ? QTY_WIDTH : 32;
    localparam int EW = 24 + 3 * QTY_WIDTH + 1;

    typedef struct packed {
        logic [23:0]                 key;
        logic signed [QTY_WIDTH-1:0] cur;
        logic signed [QTY_WIDTH-1:0] pq;
        logic signed [QTY_WIDTH-1:0] sq;
        logic                        sel;
    } t_entry;

    // saturate a 32-bit port value into the quantity width
    function automatic logic signed [QTY_WIDTH-1:0] from32(input logic [31:0] x);
        logic signed [XW-1:0] xe;
        logic                 fits;
        xe   = XW'(signed'(x));
        fits = (xe[XW-1:QTY_WIDTH-1] == {(XW-QTY_WIDTH+1){xe[XW-1]}});
        if (fits) begin
            return xe[QTY_WIDTH-1:0];
        end
        return {xe[XW-1], {(QTY_WIDTH-1){~xe[XW-1]}}};
    endfunction

    function automatic logic signed [31:0] to32(input logic signed [QTY_WIDTH-1:0] x);
        return 32'(x);
    endfunction

    function automatic logic signed [QTY_WIDTH-1:0] sat_add(
        input logic signed [QTY_WIDTH-1:0] a,
        input logic signed [QTY_WIDTH-1:0] b
    );
        logic [QTY_WIDTH:0] s;
        s = {a[QTY_WIDTH-1], a} + {b[QTY_WIDTH-1], b};
        if (s[QTY_WIDTH] != s[QTY_WIDTH-1]) begin
            return {s[QTY_WIDTH], {(QTY_WIDTH-1){~s[QTY_WIDTH]}}};
        end
        return s[QTY_WIDTH-1:0];
    endfunction

    function automatic logic signed [QTY_WIDTH-1:0] sat_sub(
        input logic signed [QTY_WIDTH-1:0] a,
        input logic signed [QTY_WIDTH-1:0] b
    );
        logic [QTY_WIDTH:0] s;
        s = {a[QTY_WIDTH-1], a} - {b[QTY_WIDTH-1], b};
        if (s[QTY_WIDTH] != s[QTY_WIDTH-1]) begin
            return {s[QTY_WIDTH], {(QTY_WIDTH-1){~s[QTY_WIDTH]}}};
        end
        return s[QTY_WIDTH-1:0];
    endfunction

    spkat_pkg::t_state r_state, n_state;
    spkat_pkg::t_in    r_in, n_in;
    logic [CW-1:0]     r_lo, n_lo;
    logic [CW-1:0]     r_hi, n_hi;
    logic [CW-1:0]     r_idx, n_idx;
    t_entry            r_ent, n_ent;
    logic              r_ent_vld, n_ent_vld;
    logic [1:0]        r_status, n_status;
    logic [8:0]        r_pos, n_pos;
    logic [CW-1:0]     r_fill, n_fill;
    logic [CW-1:0]     r_sel_cnt, n_sel_cnt;
    logic              r_dirty, n_dirty;
    logic [1:0]        r_level_action;
    spkat_pkg::t_out   r_out, n_out;
    logic              r_out_valid, n_out_valid;

    logic              mem_rd_en;
    logic [AW-1:0]     mem_rd_addr;
    logic [EW-1:0]     mem_rd_data;
    logic              mem_wr_en;
    logic [AW-1:0]     mem_wr_addr;
    logic [EW-1:0]     mem_wr_data;

    t_entry                      rd_ent;
    t_entry                      new_ent;
    logic [23:0]                 in_key;
    logic [CW:0]                 mid_sum;
    logic [CW-1:0]               mid;
    logic                        pos_bad;
    logic signed [QTY_WIDTH-1:0] level;

    // entry memory
    spkat_mem #(
        .DEPTH (TABLE_DEPTH),
        .WIDTH (EW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rd_en   (mem_rd_en),
        .i_rd_addr (mem_rd_addr),
        .o_rd_data (mem_rd_data),
        .i_wr_en   (mem_wr_en),
        .i_wr_addr (mem_wr_addr),
        .i_wr_data (mem_wr_data)
    );

    // config register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level_action <= spkat_pkg::LA_ADD;
        end else if (i_cfg_wr_en) begin
            r_level_action <= i_cfg_wr_data;
        end
    end

    // helpers around the current item
    assign rd_ent  = t_entry'(mem_rd_data);
    assign in_key  = {r_in.item_key, r_in.supplier_key};
    assign mid_sum = {1'b0, r_lo} + {1'b0, r_hi} - (CW+1)'(1);
    assign mid     = mid_sum[CW:1];
    assign pos_bad = (32'(r_in.position) >= 32'(r_fill))
                  || (32'(r_in.position) >= 32'(TABLE_DEPTH));

    // level of the finished entry
    always_comb begin
        case (r_level_action)
            spkat_pkg::LA_SUB: level = sat_sub(r_ent.cur, r_ent.sq);
            spkat_pkg::LA_OVR: level = r_ent.sq;
            default:           level = sat_add(r_ent.cur, r_ent.sq);
        endcase
    end

    // next state, memory control and result
    always_comb begin
        n_state     = r_state;
        n_in        = r_in;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_idx       = r_idx;
        n_ent       = r_ent;
        n_ent_vld   = r_ent_vld;
        n_status    = r_status;
        n_pos       = r_pos;
        n_fill      = r_fill;
        n_sel_cnt   = r_sel_cnt;
        n_dirty     = r_dirty;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;
        mem_rd_en   = 1'b0;
        mem_rd_addr = AW'(r_idx);
        mem_wr_en   = 1'b0;
        mem_wr_addr = AW'(r_idx);
        mem_wr_data = mem_rd_data;
        new_ent     = rd_ent;

        case (r_state)
            spkat_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_in = i_in_item;
                    case (i_in_item.cmd)
                        spkat_pkg::CMD_ADD: begin
                            n_lo    = '0;
                            n_hi    = r_fill;
                            n_state = spkat_pkg::S_SEARCH;
                        end
                        spkat_pkg::CMD_READ, spkat_pkg::CMD_WRITE: begin
                            n_state = spkat_pkg::S_ACCESS;
                        end
                        default: begin
                            n_fill    = '0;
                            n_sel_cnt = '0;
                            n_dirty   = 1'b0;
                            n_status  = spkat_pkg::ST_OK;
                            n_pos     = '0;
                            n_ent_vld = 1'b0;
                            n_state   = spkat_pkg::S_EMIT;
                        end
                    endcase
                end
            end

            // positional access: range check, then read
            spkat_pkg::S_ACCESS: begin
                n_pos = 9'(r_in.position);
                if (pos_bad) begin
                    n_status  = spkat_pkg::ST_RANGE;
                    n_ent_vld = 1'b0;
                    n_state   = spkat_pkg::S_EMIT;
                end else begin
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = AW'(r_in.position);
                    n_state     = spkat_pkg::S_ACC_DATA;
                end
            end

            spkat_pkg::S_ACC_DATA: begin
                if (r_in.cmd == spkat_pkg::CMD_WRITE) begin
                    new_ent.cur = from32(r_in.current_qty);
                    new_ent.pq  = from32(r_in.import_primary_qty);
                    new_ent.sq  = from32(r_in.import_stock_qty);
                    new_ent.sel = r_in.selected;
                    mem_wr_en   = 1'b1;
                    mem_wr_addr = AW'(r_in.position);
                    mem_wr_data = EW'(new_ent);
                    if (rd_ent.sel != r_in.selected) begin
                        n_dirty = 1'b1;
                        if (r_in.selected) begin
                            n_sel_cnt = r_sel_cnt + CW'(1);
                        end else if (r_sel_cnt != '0) begin
                            n_sel_cnt = r_sel_cnt - CW'(1);
                        end
                    end
                end
                n_ent     = new_ent;
                n_ent_vld = 1'b1;
                n_status  = spkat_pkg::ST_OK;
                n_state   = spkat_pkg::S_EMIT;
            end

            // binary search over [lo, hi)
            spkat_pkg::S_SEARCH: begin
                if (r_lo < r_hi) begin
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = AW'(mid);
                    n_idx       = mid;
                    n_state     = spkat_pkg::S_PROBE;
                end else begin
                    n_pos = 9'(r_lo);
                    if (r_fill >= CW'(TABLE_DEPTH)) begin
                        n_status  = spkat_pkg::ST_FULL;
                        n_ent_vld = 1'b0;
                        n_state   = spkat_pkg::S_EMIT;
                    end else begin
                        n_idx   = r_fill;
                        n_state = spkat_pkg::S_SHIFT_RD;
                    end
                end
            end

            spkat_pkg::S_PROBE: begin
                if (rd_ent.key == in_key) begin
                    new_ent.pq  = sat_add(rd_ent.pq, from32(r_in.import_primary_qty));
                    new_ent.sq  = sat_add(rd_ent.sq, from32(r_in.import_stock_qty));
                    mem_wr_en   = 1'b1;
                    mem_wr_data = EW'(new_ent);
                    n_ent       = new_ent;
                    n_ent_vld   = 1'b1;
                    n_status    = spkat_pkg::ST_MERGED;
                    n_pos       = 9'(r_idx);
                    n_state     = spkat_pkg::S_EMIT;
                end else begin
                    if (rd_ent.key > in_key) begin
                        n_hi = r_idx;
                    end else begin
                        n_lo = r_idx + CW'(1);
                    end
                    n_state = spkat_pkg::S_SEARCH;
                end
            end

            // move entries up one slot, top first, then insert
            spkat_pkg::S_SHIFT_RD: begin
                if (r_idx > r_lo) begin
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = AW'(r_idx - CW'(1));
                    n_state     = spkat_pkg::S_SHIFT_WR;
                end else begin
                    new_ent.key = in_key;
                    new_ent.cur = '0;
                    new_ent.pq  = from32(r_in.import_primary_qty);
                    new_ent.sq  = from32(r_in.import_stock_qty);
                    new_ent.sel = 1'b1;
                    mem_wr_en   = 1'b1;
                    mem_wr_addr = AW'(r_lo);
                    mem_wr_data = EW'(new_ent);
                    n_ent       = new_ent;
                    n_ent_vld   = 1'b1;
                    n_fill      = r_fill + CW'(1);
                    n_sel_cnt   = r_sel_cnt + CW'(1);
                    n_status    = spkat_pkg::ST_OK;
                    n_state     = spkat_pkg::S_EMIT;
                end
            end

            spkat_pkg::S_SHIFT_WR: begin
                mem_wr_en   = 1'b1;
                mem_wr_data = mem_rd_data;
                n_idx       = r_idx - CW'(1);
                n_state     = spkat_pkg::S_SHIFT_RD;
            end

            // load the output register once it is free
            spkat_pkg::S_EMIT: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out.status             = r_status;
                    n_out.entry_position     = r_pos;
                    n_out.entry_item_key     = r_ent_vld ? r_ent.key[23:8] : '0;
                    n_out.entry_supplier_key = r_ent_vld ? r_ent.key[7:0] : '0;
                    n_out.entry_current_qty  = r_ent_vld ? to32(r_ent.cur) : '0;
                    n_out.entry_primary_qty  = r_ent_vld ? to32(r_ent.pq) : '0;
                    n_out.entry_stock_qty    = r_ent_vld ? to32(r_ent.sq) : '0;
                    n_out.entry_selected     = r_ent_vld && r_ent.sel;
                    n_out.new_level          = r_ent_vld ? to32(level) : '0;
                    n_out.entry_total        = 9'(r_fill);
                    n_out.selected_total     = 9'(r_sel_cnt);
                    n_out.selection_changed  = r_dirty;
                    n_out_valid              = 1'b1;
                    n_state                  = spkat_pkg::S_IDLE;
                end
            end

            default: begin
                n_state = spkat_pkg::S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= spkat_pkg::S_IDLE;
            r_fill      <= '0;
            r_sel_cnt   <= '0;
            r_dirty     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_sel_cnt   <= n_sel_cnt;
            r_dirty     <= n_dirty;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_in      <= n_in;
        r_lo      <= n_lo;
        r_hi      <= n_hi;
        r_idx     <= n_idx;
        r_ent     <= n_ent;
        r_ent_vld <= n_ent_vld;
        r_status  <= n_status;
        r_pos     <= n_pos;
        r_out     <= n_out;
    end

    assign o_in_stall  = (r_state != spkat_pkg::S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

`ifndef SYNTHESIS
    // a new result only comes out of the result state
    a_out_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state) == spkat_pkg::S_EMIT)
        else $error("result raised outside result state");

    // selection count never runs past the fill count
    a_sel_le_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sel_cnt <= r_fill)
        else $error("selection count exceeds fill count");

    // fill count stays within the table
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CW'(TABLE_DEPTH))
        else $error("fill count beyond table depth");
`endif

endmodule

/* tb/sv/sorted_pair_key_accumulate_table_tb.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sorted_pair_key_accumulate_table_tb
// Self-checking bench for the sorted pair-key accumulate table: a queue-fed
// driver offers command items, a scoreboard model predicts each result and a
// monitor compares each whole result, across level rules and idle mixes.
// ---------------------------------------------------------------------------
module sorted_pair_key_accumulate_table_tb;

    localparam int DEPTH = 256;
    localparam longint QMAX = 64'sd2147483647;
    localparam longint QMIN = -64'sd2147483648;
    localparam int CYCLE_LIMIT = 3000000;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_stall;
    spkat_pkg::t_in    in_item = '0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    spkat_pkg::t_out   out_item;
    logic              cfg_wr_en = 1'b0;
    logic [1:0]        cfg_wr_data = '0;

    sorted_pair_key_accumulate_table dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (in_valid),
        .o_in_stall    (in_stall),
        .i_in_item     (in_item),
        .o_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .o_out_item    (out_item),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data)
    );

    always #4 i_clk = ~i_clk;

    // table shadow
    logic [23:0]    tbl_key [DEPTH];
    longint         tbl_cur [DEPTH];
    longint         tbl_prim [DEPTH];
    longint         tbl_stock [DEPTH];
    logic           tbl_sel [DEPTH];
    int             tbl_fill;
    int             tbl_sel_cnt;
    logic           tbl_dirty;
    logic [1:0]     level_rule;

    spkat_pkg::t_in  pending_items [$];
    spkat_pkg::t_out expected_results [$];
    int   mismatches = 0;
    int   send_idle_pct = 0;
    int   recv_stall_pct = 0;
    int   hold_off = 0;
    longint cycles = 0;

    function automatic longint sat_q(longint v);
        if (v > QMAX) return QMAX;
        if (v < QMIN) return QMIN;
        return v;
    endfunction

    function automatic spkat_pkg::t_out entry_view(int p);
        spkat_pkg::t_out r;
        longint lvl;
        r = '0;
        r.entry_position     = 9'(p);
        r.entry_item_key     = tbl_key[p][23:8];
        r.entry_supplier_key = tbl_key[p][7:0];
        r.entry_current_qty  = 32'(tbl_cur[p]);
        r.entry_primary_qty  = 32'(tbl_prim[p]);
        r.entry_stock_qty    = 32'(tbl_stock[p]);
        r.entry_selected     = tbl_sel[p];
        case (level_rule)
            spkat_pkg::LA_OVR: lvl = tbl_stock[p];
            spkat_pkg::LA_SUB: lvl = sat_q(tbl_cur[p] - tbl_stock[p]);
            default:           lvl = sat_q(tbl_cur[p] + tbl_stock[p]);
        endcase
        r.new_level = 32'(lvl);
        return r;
    endfunction

    // predict the result of one command and update the shadow table
    function automatic spkat_pkg::t_out table_apply(spkat_pkg::t_in it);
        spkat_pkg::t_out r;
        logic [23:0] key;
        int lo, hi, mid, p;
        bit hit;
        longint ip, is_, cq;
        r = '0;
        key = {it.item_key, it.supplier_key};
        ip = longint'(it.import_primary_qty);
        is_ = longint'(it.import_stock_qty);
        cq = longint'(it.current_qty);
        p = int'(it.position);
        case (it.cmd)
            spkat_pkg::CMD_ADD: begin
                lo = 0;
                hi = tbl_fill - 1;
                hit = 0;
                while (lo <= hi && !hit) begin
                    mid = (lo + hi) / 2;
                    if (tbl_key[mid] > key) hi = mid - 1;
                    else if (tbl_key[mid] < key) lo = mid + 1;
                    else hit = 1;
                end
                if (hit) begin
                    tbl_prim[mid] = sat_q(tbl_prim[mid] + ip);
                    tbl_stock[mid] = sat_q(tbl_stock[mid] + is_);
                    r = entry_view(mid);
                    r.status = spkat_pkg::ST_MERGED;
                end else if (tbl_fill >= DEPTH) begin
                    r.status = spkat_pkg::ST_FULL;
                    r.entry_position = 9'(lo);
                end else begin
                    for (int i = tbl_fill; i > lo; i--) begin
                        tbl_key[i] = tbl_key[i-1];
                        tbl_cur[i] = tbl_cur[i-1];
                        tbl_prim[i] = tbl_prim[i-1];
                        tbl_stock[i] = tbl_stock[i-1];
                        tbl_sel[i] = tbl_sel[i-1];
                    end
                    tbl_key[lo] = key;
                    tbl_cur[lo] = 0;
                    tbl_prim[lo] = ip;
                    tbl_stock[lo] = is_;
                    tbl_sel[lo] = 1'b1;
                    tbl_fill++;
                    tbl_sel_cnt++;
                    r = entry_view(lo);
                    r.status = spkat_pkg::ST_OK;
                end
            end
            spkat_pkg::CMD_READ, spkat_pkg::CMD_WRITE: begin
                if (p >= tbl_fill) begin
                    r.status = spkat_pkg::ST_RANGE;
                    r.entry_position = 9'(p);
                end else begin
                    if (it.cmd == spkat_pkg::CMD_WRITE) begin
                        if (tbl_sel[p] != it.selected) begin
                            if (it.selected) tbl_sel_cnt++;
                            else if (tbl_sel_cnt > 0) tbl_sel_cnt--;
                            tbl_dirty = 1'b1;
                        end
                        tbl_cur[p] = cq;
                        tbl_prim[p] = ip;
                        tbl_stock[p] = is_;
                        tbl_sel[p] = it.selected;
                    end
                    r = entry_view(p);
                    r.status = spkat_pkg::ST_OK;
                end
            end
            default: begin
                tbl_fill = 0;
                tbl_sel_cnt = 0;
                tbl_dirty = 1'b0;
            end
        endcase
        r.entry_total = 9'(tbl_fill);
        r.selected_total = 9'(tbl_sel_cnt);
        r.selection_changed = tbl_dirty;
        return r;
    endfunction

    function automatic logic [31:0] rand_qty();
        case ($urandom_range(0, 5))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return 32'($urandom_range(0, 8191)) - 32'd4096;
            default: return $urandom;
        endcase
    endfunction

    // random item; keys mostly from a small pool so merges happen
    function automatic spkat_pkg::t_in rand_item(int key_span);
        spkat_pkg::t_in it;
        it.cmd = ($urandom_range(0, 99) < 55) ? spkat_pkg::CMD_ADD :
                 ($urandom_range(0, 1) ? spkat_pkg::CMD_READ : spkat_pkg::CMD_WRITE);
        if ($urandom_range(0, 199) == 0) it.cmd = spkat_pkg::CMD_CLEAR;
        if ($urandom_range(0, 9) == 0) begin
            it.item_key = 16'($urandom);
            it.supplier_key = 8'($urandom);
        end else begin
            it.item_key = 16'($urandom_range(0, key_span)) ^ 16'h8000;
            it.supplier_key = 8'($urandom_range(0, 3)) ^ 8'h80;
        end
        it.position = ($urandom_range(0, 9) == 0) ? 8'($urandom) :
                      8'($urandom_range(0, tbl_fill > 0 ? tbl_fill - 1 : 0));
        it.import_primary_qty = rand_qty();
        it.import_stock_qty = rand_qty();
        it.current_qty = rand_qty();
        it.selected = 1'($urandom);
        return it;
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || !in_stall) begin
            if (pending_items.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                in_item <= pending_items.pop_front();
                in_valid <= 1'b1;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // receiver stall, with an optional long hold-off
    always @(posedge i_clk) begin
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            out_stall <= 1'b1;
        end else begin
            out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    // monitor
    always @(posedge i_clk) begin
        spkat_pkg::t_out exp_r;
        cycles <= cycles + 1;
        if (i_rst_n && out_valid && !out_stall) begin
            if (expected_results.size() == 0) begin
                mismatches <= mismatches + 1;
                if (mismatches < 10) $display("unexpected result %p", out_item);
            end else begin
                exp_r = expected_results.pop_front();
                if (out_item !== exp_r) begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10)
                        $display("mismatch: expected %p actual %p", exp_r, out_item);
                end
            end
        end
        if (cycles > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic push_item(spkat_pkg::t_in it);
        expected_results.push_back(table_apply(it));
        pending_items.push_back(it);
    endtask

    task automatic drain();
        while (pending_items.size() > 0 || expected_results.size() > 0)
            @(posedge i_clk);
        repeat (600) @(posedge i_clk);
    endtask

    task automatic set_rule(logic [1:0] v);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(posedge i_clk);
        cfg_wr_en <= 1'b0;
        level_rule = v;
        @(posedge i_clk);
    endtask

    // queue one phase of items and hold its idle mix until they are all sent
    task automatic random_phase(int n, int span, int idle, int stall);
        send_idle_pct = idle;
        recv_stall_pct = stall;
        for (int i = 0; i < n; i++) push_item(rand_item(span));
        while (pending_items.size() > 0)
            @(posedge i_clk);
    endtask

    initial begin
        spkat_pkg::t_in it;
        tbl_fill = 0;
        tbl_sel_cnt = 0;
        tbl_dirty = 1'b0;
        level_rule = spkat_pkg::LA_ADD;
        for (int i = 0; i < DEPTH; i++) begin
            tbl_key[i] = '0; tbl_cur[i] = 0; tbl_prim[i] = 0;
            tbl_stock[i] = 0; tbl_sel[i] = 1'b0;
        end
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty-table accesses, extremes, merge saturation, write, clear
        it = '0;
        it.cmd = spkat_pkg::CMD_READ; it.position = 8'd0; push_item(it);
        it.cmd = spkat_pkg::CMD_WRITE; it.position = 8'd255; push_item(it);
        it = '0; it.cmd = spkat_pkg::CMD_ADD; it.item_key = 16'hffff;
        it.supplier_key = 8'hff;
        it.import_primary_qty = 32'sh7fffffff; it.import_stock_qty = 32'sh7fffffff;
        push_item(it); push_item(it);
        it.item_key = 16'h0000; it.supplier_key = 8'h00;
        it.import_primary_qty = 32'sh80000000; it.import_stock_qty = 32'sh80000000;
        push_item(it); push_item(it);
        it.item_key = 16'h0000; it.supplier_key = 8'h01; push_item(it);
        it = '0; it.cmd = spkat_pkg::CMD_WRITE; it.position = 8'd1;
        it.current_qty = 32'sh7fffffff;
        it.import_stock_qty = 32'sh7fffffff; it.import_primary_qty = 32'sh7fffffff;
        it.selected = 1'b0; push_item(it);
        it.cmd = spkat_pkg::CMD_READ; push_item(it);
        it.cmd = spkat_pkg::CMD_WRITE; it.position = 8'd0; it.current_qty = 32'sh80000000;
        it.import_stock_qty = 32'sh7fffffff; it.selected = 1'b1; push_item(it);
        it.position = 8'd3; push_item(it);
        it.cmd = spkat_pkg::CMD_READ; it.position = 8'd2; push_item(it);
        it.cmd = spkat_pkg::CMD_CLEAR; push_item(it);
        it.cmd = spkat_pkg::CMD_READ; it.position = 8'd0; push_item(it);
        drain();

        // fill the table to full, then hit the full flag (no receiver stalls)
        send_idle_pct = 0; recv_stall_pct = 0;
        for (int i = 0; i < DEPTH; i++) begin
            it = '0; it.cmd = spkat_pkg::CMD_ADD;
            it.item_key = 16'(($urandom_range(0, 1) ? i : 255 - i) * 3);
            it.supplier_key = 8'($urandom);
            it.import_stock_qty = rand_qty();
            it.import_primary_qty = rand_qty();
            if (tbl_fill < DEPTH) push_item(it);
        end
        while (tbl_fill < DEPTH) begin
            it.item_key = 16'($urandom); it.supplier_key = 8'($urandom);
            push_item(it);
        end
        it.item_key = 16'hffff; it.supplier_key = 8'hff;
        if ({it.item_key, it.supplier_key} != tbl_key[DEPTH-1]) push_item(it);
        it.item_key = 16'h0001; push_item(it);
        it.cmd = spkat_pkg::CMD_READ; it.position = 8'd255; push_item(it);
        it.cmd = spkat_pkg::CMD_CLEAR; push_item(it);
        drain();

        for (int rule = 0; rule < 4; rule++) begin
            set_rule(2'(rule));
            random_phase(30, 40, 0, 0);
            random_phase(25, 40, 76, 0);
            random_phase(25, 40, 0, 76);
            random_phase(25, 40, 17, 17);
            drain();
        end

        // long receiver hold-off while the sender keeps offering
        set_rule(spkat_pkg::LA_SUB);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_off = 400;
        random_phase(40, 60, 0, 0);
        drain();
        set_rule(spkat_pkg::LA_OVR);
        random_phase(30, 60, 0, 30);
        drain();

        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule

/* sim.f */
design/spkat_pkg.sv
design/spkat_mem.sv
design/sorted_pair_key_accumulate_table.sv
tb/sv/sorted_pair_key_accumulate_table_tb.sv
